// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL, used by nmeack_core. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CHK_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/nmeack_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeack_pkg
// Types, character codes and the hex digit decoder for the sentence deframer.
// ----------------------------------------------------------------------------
package nmeack_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UPA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWA  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWZ  = 8'h7A;  // 'z'
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  localparam int TDATA_W = 32;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_BODY    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] body_byte;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_t;

  // Digit value of a hex character; non-digits are upper-cased and wrap mod 256.
  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b >= CH_LOWA && b <= CH_LOWZ) begin
      c = b - CASE_GAP;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      hex_value = b - CH_ZERO;
    end else begin
      hex_value = c - CH_UPA + HEX_TEN;
    end
  endfunction

endpackage

// ===== src/nmeack_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeack_core
// Sentence state machine: phase, running XOR and high digit, plus the result
// that each byte produces.
// ----------------------------------------------------------------------------
module nmeack_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output nmeack_pkg::result_t  res
);
  import nmeack_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] running_xor;
  logic [7:0] running_xor_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic [7:0] digit;
  logic [7:0] body_xor;
  logic [7:0] rx_sum;

  assign digit    = hex_value(rx_byte);
  assign body_xor = running_xor ^ rx_byte;
  assign rx_sum   = {high_nibble, 4'b0000} + digit;

  // Next state
  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    high_nibble_next = high_nibble;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_START) begin
          phase_next       = PH_BODY;
          running_xor_next = '0;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_STAR) begin
          phase_next = PH_HI;
        end else begin
          running_xor_next = body_xor;
        end
      end
      PH_HI: begin
        high_nibble_next = digit[3:0];
        phase_next       = PH_LO;
      end
      PH_LO: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Result for the byte at hand
  always_comb begin
    res = '0;
    case (phase)
      PH_BODY: begin
        if (rx_byte != CH_STAR) begin
          res.valid        = 1'b1;
          res.kind         = KIND_BODY;
          res.body_byte    = rx_byte;
          res.computed_sum = body_xor;
        end
      end
      PH_LO: begin
        res.valid        = 1'b1;
        res.kind         = KIND_VERDICT;
        res.checksum_ok  = (rx_sum == running_xor);
        res.computed_sum = running_xor;
        res.received_sum = rx_sum;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_xor <= '0;
      high_nibble <= '0;
    end else if (step) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      high_nibble <= high_nibble_next;
    end
  end

`include "assert_macros.svh"

  `CHK_CLK(a_start_clears, step && phase == PH_HUNT && rx_byte == CH_START |=> running_xor == 8'h00 && phase == PH_BODY, "start byte did not clear the sum")
  `CHK_CLK(a_body_xor, step && phase == PH_BODY && rx_byte != CH_STAR |=> running_xor == $past(body_xor) && phase == PH_BODY, "body byte not folded into sum")
  `CHK_CLK(a_verdict_ends, step && phase == PH_LO |=> phase == PH_HUNT && $stable(running_xor), "verdict did not return to hunting")
  `CHK_CLK_ALWAYS(a_reset_hunt, rst |=> phase == PH_HUNT && running_xor == 8'h00, "reset left sentence state")

endmodule

// ===== src/nmea_sentence_checksum_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_deframer
// Hunts for '$', forwards sentence body bytes with a running XOR and reports
// one checksum verdict after the two hex digits that follow '*'.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | [7:0] rx_byte                           | -
//  m_axis   | out | [7:0] body_byte, [8] checksum_ok,       | kind
//           |     | [16:9] computed_sum, [24:17] received_sum, rest zero |
//
// One beat per cycle sustained while m_axis does not stall; each byte passes
// through the input register and then the output register before its result
// beat is presented. rst (synchronous) returns to hunting with a zero sum and
// empties both registers. A stall on m_axis holds the output register and
// backs up into the input register; s_axis keeps taking beats as long as the
// input register can move on.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_deframer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [nmeack_pkg::TDATA_W-1:0]     m_axis_tdata,   // body_byte, checksum_ok,
                                                             // computed_sum, received_sum
  output logic                               m_axis_tuser    // kind
);
  import nmeack_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  result_t    res;
  result_t    out_res;
  logic       out_valid;

  // Move the held byte into the state machine when the output side has room.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  nmeack_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {{(TDATA_W - 25){1'b0}}, out_res.received_sum,
                          out_res.computed_sum, out_res.checksum_ok, out_res.body_byte};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sentence checksum deframer. Byte streams of
// well-formed, corrupted and cut-off sentences go in through s_axis under
// random bursts and gaps. A bit-accurate tracker of the deframer predicts each
// body and verdict beat, and the m_axis side, stalled on its own pattern, is
// compared with it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import nmeack_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_ITEMS    = 1550;
  localparam int TAIL_CYCLES  = 10;
  localparam int HOLD_PERIOD  = 1500;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_LEN     = 120;

  typedef struct {
    logic [7:0] ch;
    bit         wait_idle;  // offer only once every expected beat has come back
  } rx_char_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] body_byte;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } frame_beat_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_EVERY3
  } ready_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;

  rx_char_t             rx_char_q[$];
  frame_beat_t          frame_beat_q[$];
  frame_beat_t          want;

  phase_t               trk_phase = PH_HUNT;
  logic [7:0]           trk_xor = 8'h00;
  logic [3:0]           trk_hi = 4'h0;

  bit                   in_fire = 1'b0;
  int                   err_cnt = 0;
  int                   cyc_cnt = 0;
  int                   live_items = 0;
  int                   burst_left = 1;
  int                   gap_left = 0;
  int                   rx_cyc = 0;
  int                   hold_left = 0;
  int                   mode_left = 0;
  ready_mode_t          ready_mode = RDY_ALWAYS;

  // hunting noise, a body with '$' inside, a mixed-case good checksum, non-hex
  // digits, an empty body, and '$' / '*' taken as digits
  logic [7:0] directed_seq [24] = '{
    8'h00, 8'hFF, CH_STAR,
    CH_START, 8'h00, 8'hFF, CH_START, CH_STAR, "d", "B",
    CH_START, "G", CH_STAR, "Z", "z",
    CH_START, CH_STAR, "0", "0",
    CH_START, "1", CH_STAR, CH_START, CH_STAR
  };

  nmea_sentence_checksum_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] hex_digit_val(input logic [7:0] ch);
    logic [7:0] up;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      return ch - CH_ZERO;
    end
    up = (ch >= CH_LOWA && ch <= CH_LOWZ) ? ch - CASE_GAP : ch;
    return up - CH_UPA + HEX_TEN;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < HEX_TEN) begin
      return CH_ZERO + n;
    end
    return (lower ? CH_LOWA : CH_UPA) + n - HEX_TEN;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_STAR);
    return c;
  endfunction

  // Advance the tracked deframer by one accepted byte.
  task automatic deframe_byte(input logic [7:0] b);
    frame_beat_t r;
    logic [7:0]  dig;
    case (trk_phase)
      PH_HUNT: begin
        if (b == CH_START) begin
          trk_xor   = 8'h00;
          trk_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (b == CH_STAR) begin
          trk_phase = PH_HI;
        end else begin
          trk_xor        = trk_xor ^ b;
          r.kind         = KIND_BODY;
          r.body_byte    = b;
          r.checksum_ok  = 1'b0;
          r.computed_sum = trk_xor;
          r.received_sum = 8'h00;
          frame_beat_q.insert(frame_beat_q.size(), r);
        end
      end
      PH_HI: begin
        dig       = hex_digit_val(b);
        trk_hi    = dig[3:0];
        trk_phase = PH_LO;
      end
      default: begin
        r.kind         = KIND_VERDICT;
        r.body_byte    = 8'h00;
        r.received_sum = {trk_hi, 4'h0} + hex_digit_val(b);
        r.checksum_ok  = (r.received_sum == trk_xor);
        r.computed_sum = trk_xor;
        frame_beat_q.insert(frame_beat_q.size(), r);
        trk_phase = PH_HUNT;
      end
    endcase
  endtask

  task automatic push_char(input logic [7:0] c, input bit wait_idle);
    rx_char_t item;
    item.ch        = c;
    item.wait_idle = wait_idle;
    rx_char_q.insert(rx_char_q.size(), item);
  endtask

  // One sentence: optional noise, '$', body, then a good, wrong or garbage
  // checksum. Some are cut off before '*' and run into the next sentence.
  task automatic add_sentence(input bit force_hold);
    int         mode;
    int         nlen;
    int         npre;
    logic [7:0] c;
    logic [7:0] sum;
    bit         hold;
    mode = $urandom_range(0, 19);
    hold = force_hold || ($urandom_range(0, 39) == 0);
    npre = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < npre; i++) begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (c == CH_START);
      push_char(c, hold);
      hold = 1'b0;
    end
    push_char(CH_START, hold);
    nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    sum  = 8'h00;
    for (int i = 0; i < nlen; i++) begin
      c   = body_char();
      sum = sum ^ c;
      push_char(c, 1'b0);
    end
    live_items += npre + 1 + nlen;
    if (mode == 19) begin
      return;
    end
    push_char(CH_STAR, 1'b0);
    if (mode >= 14 && mode <= 16) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    if (mode >= 17) begin
      push_char(8'($urandom_range(0, 255)), 1'b0);
      push_char(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      push_char(hex_char(sum[7:4], 1'($urandom_range(0, 1))), 1'b0);
      push_char(hex_char(sum[3:0], 1'($urandom_range(0, 1))), 1'b0);
    end
    live_items += 3;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Sender: bursts of random length with random gaps; hold a beat until taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_char_q.size() != 0 &&
                   !(rx_char_q[0].wait_idle && frame_beat_q.size() != 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_char_q[0].ch;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns plus a periodic long hold-off.
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_cyc % HOLD_PERIOD == HOLD_AT) begin
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        RDY_ALWAYS: m_axis_tready <= 1'b1;
        RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RDY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:    m_axis_tready <= (rx_cyc % 3 == 0);
      endcase
    end
  end

  // Predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      in_fire = !rst && s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        deframe_byte(s_axis_tdata);
        rx_char_q.pop_front();
      end
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (frame_beat_q.size() == 0) begin
          $error("unexpected beat: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
          err_cnt++;
        end else begin
          want = frame_beat_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(m_axis_tuser));
          check_field("body_byte", want.body_byte, m_axis_tdata[7:0]);
          check_field("checksum_ok", 8'(want.checksum_ok), 8'(m_axis_tdata[8]));
          check_field("computed_sum", want.computed_sum, m_axis_tdata[16:9]);
          check_field("received_sum", want.received_sum, m_axis_tdata[24:17]);
          check_field("tdata pad", 8'h00, 8'(m_axis_tdata[TDATA_W-1:25]));
        end
      end
    end
  end

  initial begin
    foreach (directed_seq[i]) begin
      push_char(directed_seq[i], 1'b0);
    end
    live_items = $size(directed_seq);
    // first random sentence waits for the directed part to drain
    add_sentence(1'b1);
    while (live_items < NUM_ITEMS) begin
      add_sentence(1'b0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rx_char_q.size() != 0) @(negedge clk);
    while (frame_beat_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
